FILE: sv/clx_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and classification functions for the lexer.
// No dependencies; every other file of the lexer imports this package.
package clx_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Most token bytes one character can release
  localparam int unsigned MAX_RES = 3;
  // Bundles the queue can hold
  localparam int unsigned Q_DEPTH = 2;

  // Token bytes released by one accepted character
  typedef struct packed {
    logic [1:0]           cnt;
    logic [2:0][7:0]      byte_v;
    logic [2:0]           last;
    logic [2:0]           sym;
  } res_t;

  // Lexer state carried from one character to the next
  typedef struct packed {
    logic [7:0] lk_char;
    logic       lk_valid;
    logic [7:0] held_byte;
    logic       held_valid;
    logic [7:0] prior_char;
    logic       prior_valid;
    logic       blk;
    logic       line;
  } lex_st_t;

  // State plus results while one character is worked through
  typedef struct packed {
    lex_st_t st;
    res_t    res;
  } work_t;

  // Queue fill status seen by the front, the back and the top level
  typedef struct packed {
    logic [1:0] level;
    logic       full;
    logic       empty;
  } q_stat_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return (c == CH_CARET) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRC) ||
           (c == CH_RBRC) || (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_SEMI);
  endfunction

  function automatic logic is_oper(logic [7:0] c);
    return (c == CH_EQ) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_PCT) || (c == CH_AMP) || (c == CH_BAR) ||
           (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic logic forms_pair(logic [7:0] a, logic [7:0] b);
    logic r;
    case (a)
      CH_EQ:    r = (b == CH_EQ);
      CH_PLUS:  r = (b == CH_PLUS) || (b == CH_EQ);
      CH_MINUS: r = (b == CH_MINUS);
      CH_STAR:  r = (b == CH_EQ);
      CH_SLASH: r = (b == CH_EQ);
      CH_PCT:   r = (b == CH_EQ);
      CH_AMP:   r = (b == CH_AMP);
      CH_BAR:   r = (b == CH_BAR);
      CH_BANG:  r = (b == CH_EQ);
      CH_LT:    r = (b == CH_EQ) || (b == CH_LT);
      CH_GT:    r = (b == CH_EQ) || (b == CH_GT);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  // Append one token byte; drop it once the bundle is full
  function automatic res_t res_push(res_t r, logic [7:0] b, logic l, logic s);
    res_t o;
    o = r;
    if (r.cnt != 2'(MAX_RES)) begin
      o.byte_v[r.cnt] = b;
      o.last[r.cnt]   = l;
      o.sym[r.cnt]    = s;
      o.cnt           = r.cnt + 2'd1;
    end
    return o;
  endfunction

  // Release the held word byte as the end of its word
  function automatic work_t flush_word(work_t w);
    work_t o;
    o = w;
    if (w.st.held_valid) begin
      o.res           = res_push(w.res, w.st.held_byte, 1'b1, 1'b0);
      o.st.held_valid = 1'b0;
    end
    return o;
  endfunction

  // Handle a character with nothing pending and no comment open
  function automatic work_t plain_char(work_t w, logic [7:0] c);
    work_t o;
    o = w;
    if (is_space(c)) begin
      o = flush_word(o);
    end else if (is_single(c)) begin
      o     = flush_word(o);
      o.res = res_push(o.res, c, 1'b1, 1'b1);
    end else if (is_oper(c)) begin
      o             = flush_word(o);
      o.st.lk_char  = c;
      o.st.lk_valid = 1'b1;
    end else if (c == CH_DOT) begin
      if (w.st.prior_valid && is_digit(w.st.prior_char)) begin
        o.st.lk_char  = c;
        o.st.lk_valid = 1'b1;
      end else begin
        o     = flush_word(o);
        o.res = res_push(o.res, c, 1'b1, 1'b1);
      end
    end else begin
      if (w.st.held_valid) begin
        o.res = res_push(o.res, w.st.held_byte, 1'b0, 1'b0);
      end
      o.st.held_byte  = c;
      o.st.held_valid = 1'b1;
    end
    return o;
  endfunction

endpackage

FILE: sv/clx_front.sv
`timescale 1ns / 1ps
// Front end: accepts characters, keeps the lexer state and classifies each
// character into a bundle of token bytes. Depends on clx_pkg.
module clx_front import clx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_line_break,
  input  q_stat_t    q_stat,
  output logic       push,
  output res_t       push_data
);

  lex_st_t st_r;
  lex_st_t st_nxt;
  work_t   w;
  logic    accept;

  // Hold off new requests while the queue has no room
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Classify one character against the current state
  always_comb begin
    logic [7:0] p;
    w.st  = st_r;
    w.res = '0;
    p     = st_r.lk_char;
    if (in_line_break) begin
      w = flush_word(w);
      if (st_r.lk_valid && !st_r.blk) begin
        w.res = res_push(w.res, st_r.lk_char, 1'b1, 1'b1);
      end
      w.st.lk_valid    = 1'b0;
      w.st.prior_valid = 1'b0;
      w.st.line        = 1'b0;
    end else begin
      if (st_r.line) begin
        // drop the rest of the line
      end else if (st_r.blk) begin
        if (st_r.lk_valid && (in_char_code == CH_SLASH)) begin
          w.st.blk      = 1'b0;
          w.st.lk_valid = 1'b0;
        end else begin
          w.st.lk_valid = (in_char_code == CH_STAR);
          w.st.lk_char  = in_char_code;
        end
      end else if (st_r.lk_valid) begin
        w.st.lk_valid = 1'b0;
        if (p == CH_DOT) begin
          // A dot between digits stays inside the word
          if (is_digit(in_char_code)) begin
            if (st_r.held_valid) begin
              w.res = res_push(w.res, st_r.held_byte, 1'b0, 1'b0);
            end
            w.st.held_byte  = p;
            w.st.held_valid = 1'b1;
          end else begin
            w     = flush_word(w);
            w.res = res_push(w.res, p, 1'b1, 1'b1);
          end
          w = plain_char(w, in_char_code);
        end else if (forms_pair(p, in_char_code)) begin
          w.res = res_push(w.res, p, 1'b0, 1'b1);
          w.res = res_push(w.res, in_char_code, 1'b1, 1'b1);
        end else if ((p == CH_SLASH) && (in_char_code == CH_SLASH)) begin
          w.st.line = 1'b1;
        end else if ((p == CH_SLASH) && (in_char_code == CH_STAR)) begin
          w.st.blk = 1'b1;
        end else begin
          w.res = res_push(w.res, p, 1'b1, 1'b1);
          w     = plain_char(w, in_char_code);
        end
      end else begin
        w = plain_char(w, in_char_code);
      end
      w.st.prior_char  = in_char_code;
      w.st.prior_valid = 1'b1;
    end
  end

  // Queue only bundles that carry token bytes
  assign push      = accept && (w.res.cnt != 2'd0);
  assign push_data = w.res;

  // Advance the state on each accepted request
  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      st_nxt = w.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: sv/clx_queue.sv
`timescale 1ns / 1ps
// Short queue of result bundles between the front and the back end.
// Depends on clx_pkg.
module clx_queue import clx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  res_t    push_data,
  input  logic    pop,
  output res_t    head,
  output q_stat_t q_stat
);

  res_t       ent_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] level_r;
  logic [1:0] level_nxt;

  assign head         = ent_r[rd_ptr_r];
  assign q_stat.level = level_r;
  assign q_stat.full  = (level_r == 2'(Q_DEPTH));
  assign q_stat.empty = (level_r == 2'd0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Store the bundle at the write slot
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/clx_back.sv
`timescale 1ns / 1ps
// Back end: walks the head bundle one token byte a cycle, while the output is not
// stalled, into the output register. Depends on clx_pkg.
module clx_back import clx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_token_byte,
  output logic       out_token_last,
  output logic       out_token_is_symbol
);

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       sym_r;
  logic       load;
  logic       take;

  // Refill the output register when it is empty or being taken
  assign load = !valid_r || !out_stall;
  assign take = load && !q_stat.empty;
  assign pop  = take && (idx_r == (head.cnt - 2'd1));

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = !q_stat.empty;
    end
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Load the next token byte
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= head.byte_v[idx_r];
      last_r <= head.last[idx_r];
      sym_r  <= head.sym[idx_r];
    end
  end

  assign out_valid           = valid_r;
  assign out_token_byte      = byte_r;
  assign out_token_last      = last_r;
  assign out_token_is_symbol = sym_r;

endmodule

FILE: sv/c_like_lexer_byte_stream.sv
`timescale 1ns / 1ps
// C-style lexer over a character stream: top level joining front, queue and back.
// Depends on clx_pkg, clx_front, clx_queue and clx_back.
//
// One character (or end-of-line marker) is accepted per cycle when not stalled and
// turned at once into zero to three token bytes, which wait in a two-bundle queue
// and leave one byte per cycle through a registered output while out_stall is low.
// Items that yield no bytes take no queue slot. The output byte rate of one per
// cycle sets the sustained figure. Input stall rises only while the queue holds
// two bundles.
module c_like_lexer_byte_stream import clx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_line_break,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_token_byte,
  output logic       out_token_last,
  output logic       out_token_is_symbol
);

  logic    push;
  res_t    push_data;
  logic    pop;
  res_t    head;
  q_stat_t q_stat;

  clx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_line_break (in_line_break),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  clx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  clx_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_byte      (out_token_byte),
    .out_token_last      (out_token_last),
    .out_token_is_symbol (out_token_is_symbol)
  );

  // A queued bundle always carries at least one token byte
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_data.cnt != 2'd0))
    else $error("empty bundle pushed");

  // The queue never overfills and never pops when empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.level <= 2'(Q_DEPTH)) && !(pop && q_stat.empty))
    else $error("queue bounds violated");

  // A pop with no push lowers the fill level by one
  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (q_stat.level == $past(q_stat.level) - 2'd1))
    else $error("queue level mismatch after pop");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for c_like_lexer_byte_stream: directed rows, then random
// source fragments, each accepted request predicted in the bench. Depends on clx_pkg.
module testbench import clx_pkg::*;;

  // One source request and one token byte as seen on the ports
  typedef struct packed {
    logic [7:0] ch;
    logic       brk;
  } lex_item_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       last;
    logic       sym;
  } tok_t;

  // Directed row: request plus, where typed, up to two literal token bytes
  typedef struct packed {
    logic [7:0] ch;
    logic       brk;
    logic       typed;
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } dir_row_t;

  localparam int   CYCLE_LIMIT = 300000;
  localparam int   RANDOM_ITEMS = 142;
  localparam int   DIR_ROWS = 28;
  localparam tok_t NO_TOK = '0;

  localparam logic [7:0] OPER_CHARS [11] = '{CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                             CH_PCT, CH_AMP, CH_BAR, CH_BANG, CH_LT, CH_GT};
  localparam logic [7:0] SEP_CHARS [12] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_CARET,
                                            CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC, CH_LBRK,
                                            CH_RBRK, CH_SEMI};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_line_break;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_token_byte;
  logic       out_token_last;
  logic       out_token_is_symbol;

  // Bench copy of the lexer state
  logic [7:0] la_char;
  logic       la_valid;
  logic [7:0] held_byte;
  logic       held_valid;
  logic [7:0] prev_char;
  logic       prev_valid;
  logic       in_blk;
  logic       in_line;

  // Token bytes released by the last predicted request
  tok_t       step_tok [3];
  int         step_n;

  tok_t       token_q [$];
  lex_item_t  frag_q [$];
  int         sent_items;
  int         mismatch_count;
  int         cycle_count;
  int         stall_left;
  bit         idle_on;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CH_LPAR,  1'b0, 1'b1, 2'd1, '{CH_LPAR, 1'b1, 1'b1}, NO_TOK},
    '{8'h00,    1'b0, 1'b1, 2'd0, NO_TOK, NO_TOK},
    '{8'hFF,    1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b0}, NO_TOK},
    '{8'hA5,    1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_TOK},
    '{8'h31,    1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_DOT,   1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{8'h35,    1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_DOT,   1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{8'h5A,    1'b1, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_PLUS,  1'b0, 1'b1, 2'd0, NO_TOK, NO_TOK},
    '{8'h00,    1'b1, 1'b1, 2'd1, '{CH_PLUS, 1'b1, 1'b1}, NO_TOK},
    '{8'h37,    1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_DOT,   1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_LBRC,  1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_EQ,    1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{8'h78,    1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{8'hFF,    1'b1, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_STAR,  1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_STAR,  1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{8'h00,    1'b1, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_STAR,  1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
    '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK}
  };

  c_like_lexer_byte_stream u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_code        (in_char_code),
    .in_line_break       (in_line_break),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_byte      (out_token_byte),
    .out_token_last      (out_token_last),
    .out_token_is_symbol (out_token_is_symbol)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- lexer predictor

  function automatic logic is_decimal(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic joins_pair(logic [7:0] a, logic [7:0] b);
    case (a)
      CH_EQ, CH_SLASH, CH_STAR, CH_PCT, CH_BANG: return b == CH_EQ;
      CH_PLUS:  return (b == CH_PLUS) || (b == CH_EQ);
      CH_MINUS: return b == CH_MINUS;
      CH_AMP:   return b == CH_AMP;
      CH_BAR:   return b == CH_BAR;
      CH_LT:    return (b == CH_EQ) || (b == CH_LT);
      CH_GT:    return (b == CH_EQ) || (b == CH_GT);
      default:  return 1'b0;
    endcase
  endfunction

  // Append one token byte; drop it once three are out for this request
  task automatic emit_tok(input logic [7:0] b, input logic l, input logic s);
    if (step_n < 3) begin
      step_tok[step_n] = '{b, l, s};
      step_n++;
    end
  endtask

  task automatic end_word();
    if (held_valid) begin
      emit_tok(held_byte, 1'b1, 1'b0);
      held_valid = 1'b0;
    end
  endtask

  // Character with nothing pending and no comment open
  task automatic lex_plain(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: end_word();
      CH_CARET, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC, CH_LBRK, CH_RBRK, CH_SEMI: begin
        end_word();
        emit_tok(c, 1'b1, 1'b1);
      end
      CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_AMP, CH_BAR, CH_BANG,
      CH_LT, CH_GT: begin
        end_word();
        la_char  = c;
        la_valid = 1'b1;
      end
      CH_DOT: begin
        if (prev_valid && is_decimal(prev_char)) begin
          la_char  = c;
          la_valid = 1'b1;
        end else begin
          end_word();
          emit_tok(c, 1'b1, 1'b1);
        end
      end
      default: begin
        if (held_valid) emit_tok(held_byte, 1'b0, 1'b0);
        held_byte  = c;
        held_valid = 1'b1;
      end
    endcase
  endtask

  // Advance the lexer state by one request and collect its token bytes
  task automatic lex_step(input logic [7:0] c, input logic brk);
    logic [7:0] p;
    step_n = 0;
    if (brk) begin
      end_word();
      if (la_valid && !in_blk) emit_tok(la_char, 1'b1, 1'b1);
      la_valid   = 1'b0;
      prev_valid = 1'b0;
      in_line    = 1'b0;
    end else begin
      if (in_line) begin
        // drop the rest of the line
      end else if (in_blk) begin
        if (la_valid && c == CH_SLASH) begin
          in_blk   = 1'b0;
          la_valid = 1'b0;
        end else begin
          la_valid = (c == CH_STAR);
          la_char  = c;
        end
      end else if (la_valid) begin
        p = la_char;
        la_valid = 1'b0;
        if (p == CH_DOT) begin
          // a digit keeps the dot inside the number, anything else splits it off
          if (is_decimal(c)) begin
            if (held_valid) emit_tok(held_byte, 1'b0, 1'b0);
            held_byte  = p;
            held_valid = 1'b1;
          end else begin
            end_word();
            emit_tok(p, 1'b1, 1'b1);
          end
          lex_plain(c);
        end else if (joins_pair(p, c)) begin
          emit_tok(p, 1'b0, 1'b1);
          emit_tok(c, 1'b1, 1'b1);
        end else if (p == CH_SLASH && c == CH_SLASH) begin
          in_line = 1'b1;
        end else if (p == CH_SLASH && c == CH_STAR) begin
          in_blk = 1'b1;
        end else begin
          emit_tok(p, 1'b1, 1'b1);
          lex_plain(c);
        end
      end else begin
        lex_plain(c);
      end
      prev_char  = c;
      prev_valid = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------- driving

  // Mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Present one request and predict it once accepted
  task automatic send_item(input lex_item_t it);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_char_code  <= it.ch;
    in_line_break <= it.brk;
    do @(posedge clk); while (in_stall);
    sent_items++;
    lex_step(it.ch, it.brk);
  endtask

  // Append one expected token byte to the scoreboard
  task automatic add_expected(input tok_t t);
    token_q = {token_q, t};
  endtask

  // Append one request to the fragment being built
  task automatic add_frag(input lex_item_t it);
    frag_q = {frag_q, it};
  endtask

  task automatic queue_predicted();
    for (int k = 0; k < step_n; k++) add_expected(step_tok[k]);
  endtask

  task automatic hold_sender();
    int n;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      n = idle_len();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_tokens();
    @(negedge clk);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
  endtask

  function automatic lex_item_t char_item(logic [7:0] c);
    return '{c, 1'b0};
  endfunction

  function automatic logic [7:0] any_word_char();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(CH_ZERO, CH_NINE));
  endfunction

  // Content for comments and noise: word, operator, dot or any byte
  function automatic logic [7:0] any_content_char();
    case ($urandom_range(0, 3))
      0: return any_word_char();
      1: return OPER_CHARS[$urandom_range(0, 10)];
      2: return CH_DOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one source fragment: mostly well-formed, some noise
  task automatic build_fragment();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(1, 5);
        repeat (n) add_frag(char_item(any_word_char()));
      end
      2: begin
        repeat ($urandom_range(1, 3))
          add_frag(char_item(8'($urandom_range(CH_ZERO, CH_NINE))));
        add_frag(char_item(CH_DOT));
        repeat ($urandom_range(0, 2))
          add_frag(char_item(8'($urandom_range(CH_ZERO, CH_NINE))));
      end
      3, 4: begin
        add_frag(char_item(OPER_CHARS[$urandom_range(0, 10)]));
        if ($urandom_range(0, 1))
          add_frag(char_item($urandom_range(0, 1) ? CH_EQ
                             : OPER_CHARS[$urandom_range(0, 10)]));
      end
      5: begin
        add_frag(char_item(CH_SLASH));
        add_frag(char_item(CH_STAR));
        repeat ($urandom_range(0, 4)) add_frag(char_item(any_content_char()));
        if ($urandom_range(0, 4) == 0) add_frag('{8'($urandom_range(0, 255)), 1'b1});
        add_frag(char_item(CH_STAR));
        add_frag(char_item(CH_SLASH));
      end
      6: begin
        add_frag(char_item(CH_SLASH));
        add_frag(char_item(CH_SLASH));
        repeat ($urandom_range(0, 3)) add_frag(char_item(any_content_char()));
        add_frag('{8'($urandom_range(0, 255)), 1'b1});
      end
      7: add_frag(char_item(SEP_CHARS[$urandom_range(0, 11)]));
      8: add_frag('{8'($urandom_range(0, 255)), 1'b1});
      default: begin
        repeat ($urandom_range(1, 3))
          add_frag('{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
      end
    endcase
  endtask

  // Random stall on the result side, driven at the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token byte %h (last %b, symbol %b)", $time,
                 out_token_byte, out_token_last, out_token_is_symbol);
        mismatch_count++;
      end else begin
        want = token_q.pop_front();
        if (out_token_byte !== want.tok_byte) begin
          $display("%0t: token_byte expected %h actual %h", $time,
                   want.tok_byte, out_token_byte);
          mismatch_count++;
        end
        if (out_token_last !== want.last) begin
          $display("%0t: token_last expected %b actual %b", $time,
                   want.last, out_token_last);
          mismatch_count++;
        end
        if (out_token_is_symbol !== want.sym) begin
          $display("%0t: token_is_symbol expected %b actual %b", $time,
                   want.sym, out_token_is_symbol);
          mismatch_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    lex_item_t it;
    int        base;
    bit        drained_mid;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = 8'h00;
    in_line_break = 1'b0;
    idle_on       = 1'b1;
    sent_items    = 0;
    drained_mid   = 1'b0;
    la_char       = 8'h00;
    la_valid      = 1'b0;
    held_byte     = 8'h00;
    held_valid    = 1'b0;
    prev_char     = 8'h00;
    prev_valid    = 1'b0;
    in_blk        = 1'b0;
    in_line       = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: literal tokens where typed, predictor otherwise
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.ch  = dir_rows[r].ch;
      it.brk = dir_rows[r].brk;
      send_item(it);
      if (dir_rows[r].typed) begin
        if (dir_rows[r].n >= 2'd1) add_expected(dir_rows[r].t0);
        if (dir_rows[r].n >= 2'd2) add_expected(dir_rows[r].t1);
      end else begin
        queue_predicted();
      end
      hold_sender();
    end
    drain_tokens();

    // Random fragments, with phases of idling switched on and off
    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      build_fragment();
      while (frag_q.size() != 0) begin
        it = frag_q.pop_front();
        send_item(it);
        queue_predicted();
        hold_sender();
      end
      if ($urandom_range(0, 11) == 0) idle_on = !idle_on;
      if (!drained_mid && sent_items - base >= RANDOM_ITEMS / 2) begin
        drain_tokens();
        drained_mid = 1'b1;
      end
    end

    drain_tokens();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/clx_pkg.sv
sv/clx_front.sv
sv/clx_queue.sv
sv/clx_back.sv
sv/c_like_lexer_byte_stream.sv
tb/testbench.sv
